// ===== src/dtq_pkg.sv =====
// Deadline timer queue: shared types, codes and helper functions.
// No dependencies; every other file imports this package.
`default_nettype none

package dtq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int T_W       = 63;
    localparam int STAMP_W   = 32;

    localparam logic [T_W-1:0] MAX63 = {T_W{1'b1}};

    // op field codes
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_REBASE = 2'd3;

    // timer_mode field codes
    localparam logic [1:0] MODE_REL  = 2'd0;
    localparam logic [1:0] MODE_ABS  = 2'd1;
    localparam logic [1:0] MODE_PER  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [1:0]     op;
        logic [3:0]     slot;
        logic [1:0]     timer_mode;
        logic           real_time_base;
        logic [T_W-1:0] amount;
        logic [T_W-1:0] now;
        logic [T_W-1:0] new_rtc_offset;
    } in_item_t;

    typedef struct packed {
        logic           kind;
        logic [3:0]     fired_slot;
        logic           already_fired;
        logic           pending;
        logic [T_W-1:0] next_delay;
        logic           last;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_ARM,
        CMD_CANCEL,
        CMD_TICK,
        CMD_REBASE,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic [1:0]       mode;
        logic             rt;
        logic [T_W-1:0]   amount;
        logic [T_W-1:0]   now;
        logic [T_W-1:0]   new_off;
    } cmd_t;

    typedef struct packed {
        logic [T_W-1:0]     deadline;
        logic [T_W-1:0]     period;
        logic [1:0]         mode;
        logic               rt;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a,
                                               input logic [T_W-1:0] b);
        logic [T_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[T_W] ? MAX63 : s[T_W-1:0];
    endfunction

    // queue order: earlier deadline first, then newer stamp, then lower slot
    function automatic logic queued_ahead(input entry_t a, input logic [IDX_W-1:0] ai,
                                          input entry_t b, input logic [IDX_W-1:0] bi);
        logic [STAMP_W-1:0] d;
        d = a.stamp - b.stamp;
        if (a.deadline != b.deadline) begin
            return a.deadline < b.deadline;
        end
        if (d == '0) begin
            return ai < bi;
        end
        return !d[STAMP_W-1];
    endfunction

endpackage

`default_nettype wire

// ===== src/dtq_front.sv =====
// Front end: takes input items, classifies them into commands, queues them.
// Depends on dtq_pkg.
`default_nettype none

module dtq_front import dtq_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       push, pop;

    always_comb begin
        dec.idx      = IDX_W'(s_data.slot);
        dec.in_range = 32'(s_data.slot) < 32'(NUM_SLOTS);
        dec.mode     = s_data.timer_mode;
        dec.rt       = s_data.real_time_base;
        dec.amount   = s_data.amount;
        dec.now      = s_data.now;
        dec.new_off  = s_data.new_rtc_offset;
        unique case (s_data.op)
            OP_ARM: begin
                // mode three and out-of-range slots leave the table alone
                dec.kind = (dec.in_range && s_data.timer_mode != MODE_RSVD) ?
                           CMD_ARM : CMD_NOP;
            end
            OP_CANCEL: dec.kind = CMD_CANCEL;
            OP_TICK:   dec.kind = CMD_TICK;
            default:   dec.kind = CMD_REBASE;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dtq_mod.sv =====
// Iterative remainder unit, one quotient bit per cycle, for periodic tick skipping.
// Depends on dtq_pkg.
`default_nettype none

module dtq_mod import dtq_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [T_W-1:0] dividend,
    input  wire logic [T_W-1:0] divisor,
    output logic                done,
    output logic [T_W-1:0]      remainder
);

    localparam logic [5:0] LAST_STEP = 6'(T_W - 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [5:0]     step_reg, step_next;
    logic [T_W-1:0] rem_reg, rem_next;
    logic [T_W-1:0] dvd_reg, dvd_next;
    logic [T_W-1:0] dvs_reg, dvs_next;
    logic [T_W:0]   trial;
    logic [T_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[T_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = diff[T_W] ? trial[T_W-1:0] : diff[T_W-1:0];
            dvd_next  = {dvd_reg[T_W-2:0], 1'b0};
            step_next = step_reg + 6'd1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dtq_back.sv =====
// Back end: slot table, queue-order scans, expiry, re-arm and rebase sequencer.
// Depends on dtq_pkg and dtq_mod.
`default_nettype none

module dtq_back import dtq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_t      cmd,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_PERIOD = 6'b010000,
        ST_MOD    = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_SLOTS);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [NUM_SLOTS-1:0] armed_reg, armed_next;
    logic [NUM_SLOTS-1:0] done_reg, done_next;
    entry_t               mem [NUM_SLOTS];
    entry_t               rd_reg;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 cmp_en_reg, cmp_en_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    entry_t               best_reg, best_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 best_valid_reg, best_valid_next;
    logic                 scan_max_reg, scan_max_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [T_W-1:0]       rtc_reg, rtc_next;
    logic                 shift_up_reg, shift_up_next;
    logic [T_W-1:0]       shift_amt_reg, shift_amt_next;
    logic                 already_reg, already_next;
    logic [T_W-1:0]       tmp_reg, tmp_next;
    out_item_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 out_free;
    logic                 qualify;
    logic                 take;
    logic [T_W-1:0]       arm_dl;
    logic [T_W-1:0]       shifted_dl;
    logic [T_W-1:0]       per_d2;
    logic                 mod_start;
    logic                 mod_done;
    logic [T_W-1:0]       mod_rem;
    logic [T_W-1:0]       mod_dvd;

    dtq_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dvd),
        .divisor   (best_reg.period),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign mod_dvd  = cmd_reg.now - tmp_reg;
    assign per_d2   = sat_add(tmp_reg, best_reg.period);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        if (cmd_reg.mode == MODE_ABS) begin
            if (cmd_reg.rt) begin
                arm_dl = (cmd_reg.amount > rtc_reg) ? cmd_reg.amount - rtc_reg : '0;
            end else begin
                arm_dl = cmd_reg.amount;
            end
        end else begin
            arm_dl = sat_add(cmd_reg.now, cmd_reg.amount);
        end
        if (shift_up_reg) begin
            shifted_dl = sat_add(best_reg.deadline, shift_amt_reg);
        end else begin
            shifted_dl = (best_reg.deadline >= shift_amt_reg) ?
                         best_reg.deadline - shift_amt_reg : '0;
        end
    end

    // scan compare stage, on the entry read in the previous cycle
    always_comb begin
        qualify = cmp_en_reg && armed_reg[rd_idx_reg] &&
                  (!scan_max_reg || (rd_reg.mode == MODE_ABS && rd_reg.rt &&
                                     !done_reg[rd_idx_reg]));
        if (!best_valid_reg) begin
            take = qualify;
        end else if (scan_max_reg) begin
            take = qualify && queued_ahead(best_reg, best_idx_reg, rd_reg, rd_idx_reg);
        end else begin
            take = qualify && queued_ahead(rd_reg, rd_idx_reg, best_reg, best_idx_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        armed_next      = armed_reg;
        done_next       = done_reg;
        rd_idx_next     = cnt_reg[IDX_W-1:0];
        cmp_en_next     = 1'b0;
        cnt_next        = cnt_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_valid_next = best_valid_reg;
        scan_max_next   = scan_max_reg;
        stamp_next      = stamp_reg;
        rtc_next        = rtc_reg;
        shift_up_next   = shift_up_reg;
        shift_amt_next  = shift_amt_reg;
        already_next    = already_reg;
        tmp_next        = tmp_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = best_reg;
        rd_addr         = cnt_reg[IDX_W-1:0];
        mod_start       = 1'b0;
        cmd_ready       = 1'b0;

        if (take) begin
            best_next       = rd_reg;
            best_idx_next   = rd_idx_reg;
            best_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next     = cmd;
                    already_next = 1'b0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cnt_next        = '0;
                best_valid_next = 1'b0;
                scan_max_next   = 1'b0;
                state_next      = ST_SCAN;
                unique case (cmd_reg.kind)
                    CMD_ARM: begin
                        wr_en   = 1'b1;
                        wr_addr = cmd_reg.idx;
                        wr_data = '{deadline: arm_dl, period: cmd_reg.amount,
                                    mode: cmd_reg.mode, rt: cmd_reg.rt, stamp: stamp_reg};
                        stamp_next = stamp_reg + 1'b1;
                        armed_next[cmd_reg.idx] = 1'b1;
                    end
                    CMD_CANCEL: begin
                        if (cmd_reg.in_range && armed_reg[cmd_reg.idx]) begin
                            armed_next[cmd_reg.idx] = 1'b0;
                        end else begin
                            already_next = 1'b1;
                        end
                    end
                    CMD_REBASE: begin
                        if (cmd_reg.new_off != rtc_reg) begin
                            rtc_next       = cmd_reg.new_off;
                            shift_up_next  = rtc_reg >= cmd_reg.new_off;
                            shift_amt_next = (rtc_reg >= cmd_reg.new_off) ?
                                             rtc_reg - cmd_reg.new_off :
                                             cmd_reg.new_off - rtc_reg;
                            done_next      = '0;
                            scan_max_next  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (cnt_reg != SCAN_END) begin
                    cmp_en_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (scan_max_reg) begin
                    // rebase: re-queue the last-ordered remaining real-time slot first
                    if (best_valid_reg) begin
                        wr_en            = 1'b1;
                        wr_data.deadline = shifted_dl;
                        wr_data.stamp    = stamp_reg;
                        stamp_next       = stamp_reg + 1'b1;
                        done_next[best_idx_reg] = 1'b1;
                    end else begin
                        scan_max_next = 1'b0;
                    end
                    cnt_next        = '0;
                    best_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end else if (cmd_reg.kind == CMD_TICK && best_valid_reg &&
                             best_reg.deadline < cmd_reg.now) begin
                    if (out_free) begin
                        out_next = '{kind: KIND_REPORT, fired_slot: 4'(best_idx_reg),
                                     already_fired: 1'b0, pending: 1'b0,
                                     next_delay: '0, last: 1'b0};
                        out_valid_next = 1'b1;
                        if (best_reg.mode == MODE_PER && best_reg.period != '0) begin
                            tmp_next   = sat_add(best_reg.deadline, best_reg.period);
                            state_next = ST_PERIOD;
                        end else begin
                            armed_next[best_idx_reg] = 1'b0;
                            cnt_next        = '0;
                            best_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end
                end else if (out_free) begin
                    out_next = '{kind: KIND_SUMMARY, fired_slot: 4'd0,
                                 already_fired: already_reg, pending: best_valid_reg,
                                 next_delay: (best_valid_reg &&
                                              best_reg.deadline > cmd_reg.now) ?
                                             best_reg.deadline - cmd_reg.now : '0,
                                 last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_PERIOD: begin
                if (cmd_reg.now >= per_d2) begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end else begin
                    wr_en            = 1'b1;
                    wr_data.deadline = tmp_reg;
                    wr_data.stamp    = stamp_reg;
                    stamp_next       = stamp_reg + 1'b1;
                    cnt_next         = '0;
                    best_valid_next  = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    wr_en            = 1'b1;
                    wr_data.deadline = cmd_reg.now - mod_rem;
                    wr_data.stamp    = stamp_reg;
                    stamp_next       = stamp_reg + 1'b1;
                    cnt_next         = '0;
                    best_valid_next  = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // slot table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        done_reg      <= done_next;
        rd_idx_reg    <= rd_idx_next;
        cnt_reg       <= cnt_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        shift_up_reg  <= shift_up_next;
        shift_amt_reg <= shift_amt_next;
        already_reg   <= already_next;
        tmp_reg       <= tmp_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            armed_reg      <= '0;
            cmp_en_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            scan_max_reg   <= 1'b0;
            stamp_reg      <= '0;
            rtc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            cmp_en_reg     <= cmp_en_next;
            best_valid_reg <= best_valid_next;
            scan_max_reg   <= scan_max_next;
            stamp_reg      <= stamp_next;
            rtc_reg        <= rtc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/deadline_timer_queue_core.sv =====
// Deadline timer queue core: top level, front end plus sequencer back end.
// Depends on dtq_pkg, dtq_front, dtq_back (which holds dtq_mod).
//
// Usage:
//  - s_valid/s_ready/s_data take one item per operation: arm, cancel, tick
//    or real-time clock rebase. A two-entry command queue sits behind
//    s_ready, so up to two items can be taken while the back end is busy.
//  - m_valid/m_ready/m_data deliver results: for a tick, one report per
//    expired slot in queue order, then always one summary (last = 1).
//  - Passes: the slot table has a single read port, so each pass reads the
//    slots one after another. Arm, cancel and tick with nothing due take
//    one pass. Each expiry adds a pass; a periodic expiry that skips missed
//    ticks also runs the bit-serial remainder unit. A rebase that changes
//    the offset does one pass per shifted real-time slot plus two.
//  - Reset (aresetn low, synchronous) disarms every slot, clears the
//    stamp counter and the real-time offset, and empties the queue.
//  - If m_ready is low the result waits in the output register and the
//    back end holds; the front keeps taking items until its queue fills.
`default_nettype none

module deadline_timer_queue_core import dtq_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // front: decode and queue
    dtq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: table, scans, expiry and output register
    dtq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
